// ===== rtl/fbpd_pkg.sv =====
package fbpd_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int TIME_W      = 32;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [15:0] DEBOUNCE_RST = 16'd50;
    localparam logic        BUZZER_RST   = 1'b1;
    localparam logic [7:0]  POLL_RST     = 8'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUZZER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL     = 2'd2;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_A     = 3'd1,
        EV_UP    = 3'd2,
        EV_DOWN  = 3'd3,
        EV_RIGHT = 3'd4
    } t_event;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              level_a;
        logic              level_up;
        logic              level_down;
        logic              level_right;
    } t_in_item;

    typedef struct packed {
        t_event     event_code;
        logic [9:0] tone_hz;
        logic [3:0] pressed_mask;
        logic       combo_active;
    } t_out_item;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic        buzzer_on;
        logic [7:0]  poll_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]                  last_poll_time;
        logic [NUM_BUTTONS-1:0]             button_pressed;
        logic [NUM_BUTTONS-1:0][TIME_W-1:0] press_time;
    } t_state;

    function automatic logic [9:0] tone_of(input logic [1:0] idx);
        logic [9:0] hz;
        case (idx)
            2'd0:    hz = 10'd440;
            2'd1:    hz = 10'd523;
            2'd2:    hz = 10'd392;
            2'd3:    hz = 10'd349;
            default: hz = 10'd0;
        endcase
        return hz;
    endfunction

endpackage

// ===== rtl/four_button_press_debouncer.sv =====
// Debounces four active-low buttons from timestamped polls and reports press
// events with a tone. One result comes back for every poll transaction, after it
// passes the input register and then the result register, and a new poll can
// be accepted in every cycle: the whole priority scan, release
// check and state update sit in one combinational step between the two
// registers. While a result waits, one more poll can sit in the input register;
// after that the input side stalls until the result is taken.
// The configuration port is always ready; write it only while the block is idle.
module four_button_press_debouncer
    import fbpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    logic      advance;
    logic      r_in_valid;
    t_in_item  r_in_item;
    t_state    r_state;
    t_state    n_state;
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item n_result;

    assign o_cfg_ready = 1'b1;

    fbpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    fbpd_step u_step (
        .i_item   (r_in_item),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
        if (advance) begin
            r_out_data <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/fbpd_cfg.sv =====
module fbpd_cfg
    import fbpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms      <= DEBOUNCE_RST;
            r_cfg.buzzer_on        <= BUZZER_RST;
            r_cfg.poll_interval_ms <= POLL_RST;
        end else if (i_we) begin
            case (i_index)
                CFG_DEBOUNCE: r_cfg.debounce_ms      <= i_data;
                CFG_BUZZER:   r_cfg.buzzer_on        <= i_data[0];
                CFG_POLL:     r_cfg.poll_interval_ms <= i_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/fbpd_step.sv =====
module fbpd_step
    import fbpd_pkg::*;
(
    input  t_in_item  i_item,
    input  t_state    i_state,
    input  t_cfg      i_cfg,
    output t_state    o_state,
    output t_out_item o_result
);

    logic [NUM_BUTTONS-1:0] lv;
    logic [TIME_W-1:0]      since_poll;
    logic [TIME_W-1:0]      held;
    logic                   found;
    t_state                 st;
    t_out_item              res;

    assign lv = {i_item.level_right, i_item.level_down, i_item.level_up, i_item.level_a};

    always_comb begin
        st         = i_state;
        res        = '0;
        found      = 1'b0;
        held       = '0;
        since_poll = i_item.now_ms - i_state.last_poll_time;
        if (since_poll >= {24'd0, i_cfg.poll_interval_ms}) begin
            st.last_poll_time = i_item.now_ms;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                if (!found && !lv[i] && !i_state.button_pressed[i]) begin
                    found                = 1'b1;
                    st.button_pressed[i] = 1'b1;
                    st.press_time[i]     = i_item.now_ms;
                    res.event_code       = t_event'(3'(i + 1));
                    res.tone_hz          = i_cfg.buzzer_on ? tone_of(2'(i)) : 10'd0;
                end
            end
            if (!found) begin
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    held = i_item.now_ms - i_state.press_time[i];
                    if (lv[i] && i_state.button_pressed[i] &&
                        held > {16'd0, i_cfg.debounce_ms}) begin
                        st.button_pressed[i] = 1'b0;
                    end
                end
            end
        end
        res.pressed_mask = st.button_pressed;
        res.combo_active = ($countones(st.button_pressed) > 1);
    end

    assign o_state  = st;
    assign o_result = res;

endmodule

// ===== rtl/fbpd_checker.sv =====
module fbpd_assertions
    import fbpd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // a stalled transaction keeps its result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // reported button is marked pressed
    a_event_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_out_data.event_code == EV_NONE) ||
            (i_out_data.event_code == EV_A     && i_out_data.pressed_mask[0]) ||
            (i_out_data.event_code == EV_UP    && i_out_data.pressed_mask[1]) ||
            (i_out_data.event_code == EV_DOWN  && i_out_data.pressed_mask[2]) ||
            (i_out_data.event_code == EV_RIGHT && i_out_data.pressed_mask[3]))
        else $error("event without pressed mark");

    a_combo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            i_out_data.combo_active == ($countones(i_out_data.pressed_mask) > 1))
        else $error("combo flag disagrees with mask");

    a_tone_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.tone_hz != 10'd0 |->
            i_out_data.event_code != EV_NONE)
        else $error("tone without event");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind four_button_press_debouncer fbpd_assertions u_fbpd_assertions (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
